[rtl/core/shb_pkg.sv]
// Shared types, constants and controller/datapath interface for the Shirley background block.
package shb_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam logic [7:0] ITER_LIMIT_RST = 8'd50;
	localparam logic [31:0] TOLERANCE_RST = 32'd4295;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd1;

	// dividend is |dy| (32b) times |area| (47b)
	localparam int DIV_W = 80;
	localparam logic [41:0] QUO_CAP = 42'h100_0000_0000;

	typedef struct packed {
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
		logic last_point;
	} in_t;

	typedef struct packed {
		logic signed [31:0] background;
		logic last_result;
	} out_t;

	typedef struct packed {
		logic load;
		logic idx_clr;
		logic idx_inc;
		logic init_wr;
		logic int_start;
		logic sig0;
		logic sig;
		logic mul;
		logic acc;
		logic conv0;
		logic conv1;
		logic conv2;
		logic prev_clr;
		logic prev_upd;
		logic rm0;
		logic rm1;
		logic rm2;
		logic div_step;
		logic bwr;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic prev_zero;
		logic conv_hit;
		logic a_zero;
		logic div_last;
	} dp_sts_t;

endpackage

[rtl/core/shb_dp.sv]
// Datapath: point memories, trapezoid integrator, convergence test and rescale divider.
module shb_dp import shb_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  dp_cmd_t cmd,
	input  in_t in_data,
	input  logic [31:0] tolerance,
	output dp_sts_t sts,
	output out_t out_data
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic signed [31:0] x_mem [MAX_POINTS];
	logic signed [31:0] y_mem [MAX_POINTS];
	logic signed [31:0] b_mem [MAX_POINTS];
	logic signed [47:0] a_mem [MAX_POINTS];

	logic [CW-1:0] cnt_q;
	logic [AW-1:0] last_idx_q, idx_q, wi;
	logic full, wr_en;
	logic signed [31:0] ya_q, yb_q, rd_x, rd_y, rd_b;
	logic signed [47:0] rd_a;
	logic [31:0] magdy_q;
	logic dy_neg_q;

	logic signed [31:0] prev_sig_q, xprev_q, sig_q, dx_q, sig_c, dx_c;
	logic signed [32:0] ssum;
	logic signed [64:0] prod_q;
	logic signed [47:0] acc_q, prev_q, acc_nxt, term;
	logic signed [49:0] acc_sum;

	logic [46:0] magp;
	logic [55:0] pl_q;
	logic [54:0] ph_q;
	logic [79:0] psum_q;
	logic signed [48:0] adiff;
	logic [48:0] dmag;

	logic [46:0] maga, dvs;
	logic [55:0] r0_q;
	logic [54:0] r1_q;
	logic neg_q;
	logic [DIV_W-1:0] dvd_q;
	logic [46:0] rem_q;
	logic [47:0] rnext;
	logic ge;
	logic [41:0] quo_q, qn;
	logic [6:0] dcnt_q;
	logic signed [42:0] bfull;
	logic signed [31:0] bsat;
	out_t out_q;

	function automatic logic signed [31:0] sat31(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'sd2147483647)
			r = 32'sd2147483647;
		else if (v < -33'sd2147483647)
			r = -32'sd2147483647;
		else
			r = v[31:0];
		return r;
	endfunction

	// load side
	assign full = cnt_q == CW'(MAX_POINTS);
	assign wi = full ? AW'(MAX_POINTS - 1) : cnt_q[AW-1:0];
	assign wr_en = cmd.load && (in_data.last_point || !full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.load) begin
				if (in_data.last_point)
					cnt_q <= '0;
				else if (!full)
					cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_mem[wi] <= in_data.x_value;
			y_mem[wi] <= in_data.y_value;
			if (wi == '0)
				ya_q <= in_data.y_value;
			if (in_data.last_point) begin
				yb_q <= in_data.y_value;
				last_idx_q <= wi;
			end
		end
		rd_x <= x_mem[idx_q];
		rd_y <= y_mem[idx_q];
		rd_b <= b_mem[idx_q];
		rd_a <= a_mem[idx_q];
		if (cmd.init_wr || cmd.bwr)
			b_mem[idx_q] <= cmd.init_wr ? ya_q : bsat;
		if (cmd.int_start)
			a_mem[0] <= '0;
		else if (cmd.acc)
			a_mem[idx_q] <= acc_nxt;
	end

	// integration
	assign sig_c = sat31(33'(rd_y) - 33'(rd_b));
	assign dx_c = sat31(33'(rd_x) - 33'(xprev_q));
	assign ssum = 33'(sig_q) + 33'(prev_sig_q);
	assign term = prod_q[64:17];
	assign acc_sum = 50'(acc_q) + 50'(term);
	always_comb begin
		if (acc_sum > 50'sd140737488355327)
			acc_nxt = 48'sd140737488355327;
		else if (acc_sum < -50'sd140737488355327)
			acc_nxt = -48'sd140737488355327;
		else
			acc_nxt = acc_sum[47:0];
	end

	// convergence test
	assign magp = prev_q[47] ? 47'(-prev_q) : prev_q[46:0];
	assign adiff = 49'(acc_q) - 49'(prev_q);
	assign dmag = adiff[48] ? 49'(-adiff) : adiff;

	// rescale
	assign maga = rd_a[47] ? 47'(-rd_a) : rd_a[46:0];
	assign dvs = acc_q[47] ? 47'(-acc_q) : acc_q[46:0];
	assign rnext = {rem_q, dvd_q[DIV_W-1]};
	assign ge = rnext >= {1'b0, dvs};
	assign qn = {quo_q[40:0], ge};
	assign bfull = neg_q ? 43'(ya_q) - 43'(quo_q) : 43'(ya_q) + 43'(quo_q);
	always_comb begin
		if (bfull > 43'sd2147483647)
			bsat = 32'sd2147483647;
		else if (bfull < -43'sd2147483648)
			bsat = -32'sd2147483648;
		else
			bsat = bfull[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			acc_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.prev_clr)
				prev_q <= '0;
			else if (cmd.prev_upd)
				prev_q <= acc_q;
			if (cmd.int_start)
				acc_q <= '0;
			else if (cmd.acc)
				acc_q <= acc_nxt;
			if (cmd.rm2)
				dcnt_q <= 7'(DIV_W);
			else if (cmd.div_step)
				dcnt_q <= dcnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_wr) begin
			magdy_q <= (yb_q < ya_q) ? 32'(33'(ya_q) - 33'(yb_q))
				: 32'(33'(yb_q) - 33'(ya_q));
			dy_neg_q <= yb_q < ya_q;
		end
		if (cmd.sig0) begin
			prev_sig_q <= sig_c;
			xprev_q <= rd_x;
		end
		if (cmd.sig) begin
			sig_q <= sig_c;
			dx_q <= dx_c;
			xprev_q <= rd_x;
		end
		if (cmd.mul) begin
			prod_q <= {{32{ssum[32]}}, ssum} * {{33{dx_q[31]}}, dx_q};
			prev_sig_q <= sig_q;
		end
		if (cmd.conv0)
			pl_q <= tolerance * magp[23:0];
		if (cmd.conv1)
			ph_q <= tolerance * magp[46:24];
		if (cmd.conv2)
			psum_q <= 80'(pl_q) + (80'(ph_q) << 24);
		if (cmd.rm0) begin
			r0_q <= magdy_q * maga[23:0];
			neg_q <= dy_neg_q ^ rd_a[47] ^ acc_q[47];
		end
		if (cmd.rm1)
			r1_q <= magdy_q * maga[46:24];
		if (cmd.rm2) begin
			dvd_q <= 80'(r0_q) + (80'(r1_q) << 24);
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			rem_q <= ge ? 47'(rnext - {1'b0, dvs}) : rnext[46:0];
			quo_q <= (qn > QUO_CAP) ? QUO_CAP : qn;
		end
		if (cmd.out_load) begin
			out_q.background <= rd_b;
			out_q.last_result <= idx_q == last_idx_q;
		end
	end

	assign sts.idx_last = idx_q == last_idx_q;
	assign sts.prev_zero = prev_q == '0;
	assign sts.conv_hit = {dmag, 32'd0} < {1'b0, psum_q};
	assign sts.a_zero = acc_q == '0;
	assign sts.div_last = dcnt_q == 7'd1;
	assign out_data = out_q;

endmodule

[rtl/core/shb_ctrl.sv]
// Controller: sequences load, passes of integrate/test/rescale, and result output.
module shb_ctrl import shb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  logic [7:0] iter_limit,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_INIT  = 5'd1;
	localparam logic [4:0] S_I0RD  = 5'd2;
	localparam logic [4:0] S_I0SIG = 5'd3;
	localparam logic [4:0] S_IRD   = 5'd4;
	localparam logic [4:0] S_ISIG  = 5'd5;
	localparam logic [4:0] S_IMUL  = 5'd6;
	localparam logic [4:0] S_IACC  = 5'd7;
	localparam logic [4:0] S_CV0   = 5'd8;
	localparam logic [4:0] S_CV1   = 5'd9;
	localparam logic [4:0] S_CV2   = 5'd10;
	localparam logic [4:0] S_CV3   = 5'd11;
	localparam logic [4:0] S_RRD   = 5'd12;
	localparam logic [4:0] S_RM0   = 5'd13;
	localparam logic [4:0] S_RM1   = 5'd14;
	localparam logic [4:0] S_RM2   = 5'd15;
	localparam logic [4:0] S_RDIV  = 5'd16;
	localparam logic [4:0] S_RWB   = 5'd17;
	localparam logic [4:0] S_ORD   = 5'd18;
	localparam logic [4:0] S_OLD   = 5'd19;
	localparam logic [4:0] S_OWAIT = 5'd20;

	logic [4:0] state_q, state_nxt;
	logic [7:0] pass_q;
	logic pass_clr, pass_inc;
	logic [8:0] pass_next;

	assign pass_next = {1'b0, pass_q} + 9'd1;
	assign in_stall = state_q != S_LOAD;
	assign out_valid = state_q == S_OWAIT;

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		pass_clr = 1'b0;
		pass_inc = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.idx_clr = 1'b1;
						state_nxt = S_INIT;
					end
				end
			end
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					cmd.prev_clr = 1'b1;
					pass_clr = 1'b1;
					if (iter_limit == 8'd0) begin
						state_nxt = S_ORD;
					end else begin
						cmd.int_start = 1'b1;
						state_nxt = S_I0RD;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_I0RD: state_nxt = S_I0SIG;
			S_I0SIG: begin
				cmd.sig0 = 1'b1;
				if (sts.idx_last) begin
					state_nxt = S_CV0;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt = S_IRD;
				end
			end
			S_IRD: state_nxt = S_ISIG;
			S_ISIG: begin
				cmd.sig = 1'b1;
				state_nxt = S_IMUL;
			end
			S_IMUL: begin
				cmd.mul = 1'b1;
				state_nxt = S_IACC;
			end
			S_IACC: begin
				cmd.acc = 1'b1;
				if (sts.idx_last) begin
					state_nxt = S_CV0;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt = S_IRD;
				end
			end
			S_CV0: begin
				cmd.conv0 = 1'b1;
				state_nxt = S_CV1;
			end
			S_CV1: begin
				cmd.conv1 = 1'b1;
				state_nxt = S_CV2;
			end
			S_CV2: begin
				cmd.conv2 = 1'b1;
				state_nxt = S_CV3;
			end
			S_CV3: begin
				cmd.idx_clr = 1'b1;
				if (!sts.prev_zero && sts.conv_hit) begin
					state_nxt = S_ORD;
				end else begin
					cmd.prev_upd = 1'b1;
					state_nxt = S_RRD;
				end
			end
			S_RRD: state_nxt = S_RM0;
			S_RM0: begin
				cmd.rm0 = 1'b1;
				state_nxt = S_RM1;
			end
			S_RM1: begin
				cmd.rm1 = 1'b1;
				state_nxt = S_RM2;
			end
			S_RM2: begin
				cmd.rm2 = 1'b1;
				// zero total area: quotient stays cleared, background is first y
				state_nxt = sts.a_zero ? S_RWB : S_RDIV;
			end
			S_RDIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_nxt = S_RWB;
			end
			S_RWB: begin
				cmd.bwr = 1'b1;
				if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					pass_inc = 1'b1;
					if (pass_next >= {1'b0, iter_limit}) begin
						state_nxt = S_ORD;
					end else begin
						cmd.int_start = 1'b1;
						state_nxt = S_I0RD;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt = S_RRD;
				end
			end
			S_ORD: state_nxt = S_OLD;
			S_OLD: begin
				cmd.out_load = 1'b1;
				state_nxt = S_OWAIT;
			end
			S_OWAIT: begin
				if (!out_stall) begin
					if (sts.idx_last) begin
						state_nxt = S_LOAD;
					end else begin
						cmd.idx_inc = 1'b1;
						state_nxt = S_ORD;
					end
				end
			end
			default: state_nxt = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			pass_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (pass_clr)
				pass_q <= '0;
			else if (pass_inc)
				pass_q <= pass_next[7:0];
		end
	end

endmodule

[rtl/core/shirley_background.sv]
// Loading takes one point per cycle while in_stall is low; the last point starts init, which
// sets each background to the first y. Each pass integrates, tests convergence and, unless
// converged, rescales each point by the one-bit-per-cycle 80-step divider; results follow.
// One spectrum at a time; no new point is taken until the last result transfers.
// Reset (arst_n, async, active low) clears the controller, point count and registers
// to iteration_limit 50 and tolerance 4295; point memories hold no reset value.
module shirley_background import shb_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	logic [7:0] iter_limit_q;
	logic [31:0] tolerance_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_limit_q <= ITER_LIMIT_RST;
			tolerance_q <= TOLERANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ITER_LIMIT: iter_limit_q <= cfg_data[7:0];
				CFG_TOLERANCE: tolerance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	shb_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_last(in_data.last_point),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.iter_limit(iter_limit_q),
		.sts(sts),
		.cmd(cmd)
	);

	shb_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.in_data(in_data),
		.tolerance(tolerance_q),
		.sts(sts),
		.out_data(out_data)
	);

endmodule
